// ===== hdl/sha_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
`default_nettype none
package sha_pkg;

    // Front-to-back beat: one byte to load, or a close-of-message marker.
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_cmd;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;

    // Round constants.
    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: input queue and hash engine.
//
// Usage: push one message byte per beat on i_has_byte/i_data_byte, with
// i_end_of_message on the last beat (an end beat with no byte is allowed,
// so an empty message can be hashed; a beat with neither is ignored).
// Beats are taken while full is low and wait in a QUEUE_DEPTH-entry queue.
// Flow: each byte passes through idle and one load in the engine, which
// takes no new beat until it is back in idle; every 64th byte adds the
// rounds and the feed-forward add of one compression.
// Closing: after the end beat the engine loads the 0x80 byte, the zero fill
// and eight length bytes and runs one or two compressions, after which the
// first digest word appears, empty goes low and each word is taken with pop;
// o_last_word marks the eighth.
// While the receiver stalls the engine holds the current digest word; the
// queue keeps taking beats until it is full, then full holds off the sender.
// Reset (synchronous, active low) empties the queue and reloads the
// initial hash value.
`default_nettype none
module sha256_stream_hasher
    import sha_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         push,
    output logic        full,
    input  wire         i_has_byte,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_end_of_message,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    t_cmd w_in_cmd, w_q_cmd;
    logic w_q_empty, w_q_pop;

    assign w_in_cmd = '{has_byte: i_has_byte, data_byte: i_data_byte,
                        end_of_message: i_end_of_message};

    sha_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk, .i_rst_n,
        .i_push (push),
        .i_cmd  (w_in_cmd),
        .o_full (full),
        .i_pop  (w_q_pop),
        .o_cmd  (w_q_cmd),
        .o_empty(w_q_empty)
    );

    sha_engine u_engine (
        .i_clk, .i_rst_n,
        .i_cmd        (w_q_cmd),
        .i_cmd_valid  (!w_q_empty),
        .o_cmd_pop    (w_q_pop),
        .o_digest_word,
        .o_word_index,
        .o_last_word,
        .o_empty      (empty),
        .i_pop        (pop)
    );

endmodule
`default_nettype wire

// ===== hdl/sha_fifo.sv =====
// Small command queue between the byte front end and the hash engine.
`default_nettype none
module sha_fifo
    import sha_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  wire t_cmd  i_cmd,
    output logic       o_full,
    input  wire        i_pop,
    output t_cmd       o_cmd,
    output logic       o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd             r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign o_cmd     = r_mem[r_rp];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Storage is written at the tail only.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(w_do_push) - (AW+1)'(w_do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count overflow");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !w_do_pop) |=> o_full) else $error("full dropped without pop");
    a_empty_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty && !i_push) |=> o_empty) else $error("empty lost without push");

endmodule
`default_nettype wire

// ===== hdl/sha_engine.sv =====
// Back end: block packing, padding, 64-round compression and digest output.
`default_nettype none
module sha_engine
    import sha_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cmd   i_cmd,
    input  wire         i_cmd_valid,
    output logic        o_cmd_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_empty,
    input  wire         i_pop
);
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_RND  = 7'b0000100,
        ST_ADD  = 7'b0001000,
        ST_PAD  = 7'b0010000,
        ST_LEN  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } t_state;

    t_state        r_state, n_state;
    logic [31:0]   r_h [8];
    logic [31:0]   r_v [8];
    logic [31:0]   r_w [16];
    logic [5:0]    r_fill;
    logic [63:0]   r_len;
    logic [63:0]   r_len_snap;
    logic [5:0]    r_rnd;
    logic [2:0]    r_oi;
    logic          r_closing;
    logic [1:0]    r_ret;       // kind of byte being loaded: message, padding or length
    logic [7:0]    r_byte;

    logic [31:0]   w_wcur, w_wnew, w_t1, w_t2, w_s0, w_s1, w_ch, w_mj, w_g0, w_g1;
    logic [7:0]    w_lbyte;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_PAD  = 2'd1;
    localparam logic [1:0] RET_LEN  = 2'd2;

    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;

    // Schedule and round datapath, one round per cycle.
    always_comb begin
        w_g1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_g0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_wnew = w_g1 + r_w[9] + w_g0 + r_w[0];
        w_wcur = (r_rnd < 6'd16) ? r_w[0] : w_wnew;
        w_s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        w_ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_t1 = r_v[7] + w_s1 + w_ch + round_k(r_rnd) + w_wcur;
        w_s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        w_mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_t2 = w_s0 + w_mj;
        w_lbyte = r_len_snap[63:56];
    end

    // Output fields.
    assign o_empty       = (r_state != ST_OUT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 3'd7);

    // Next-state selection.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_cmd_valid) begin
                n_state = i_cmd.has_byte ? ST_LOAD
                        : (i_cmd.end_of_message ? ST_PAD : ST_IDLE);
            end
            ST_LOAD: begin
                // The length bytes always end exactly on a block boundary.
                if (r_fill == 6'd63) begin
                    n_state = ST_RND;
                end else if (r_ret == RET_LEN) begin
                    n_state = ST_LEN;
                end else if (r_ret == RET_PAD) begin
                    n_state = (r_fill == LEN_FILL - 6'd1) ? ST_LEN : ST_PAD;
                end else begin
                    n_state = r_closing ? ST_PAD : ST_IDLE;
                end
            end
            ST_RND: if (r_rnd == 6'd63) begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (r_ret == RET_LEN) begin
                    n_state = ST_OUT;
                end else if (r_ret == RET_PAD || r_closing) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_PAD:  n_state = ST_LOAD;
            ST_LEN:  n_state = ST_LOAD;
            ST_OUT: if (i_pop && r_oi == 3'd7) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and data registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_len     <= '0;
            r_closing <= 1'b0;
            r_ret     <= RET_IDLE;
            r_oi      <= '0;
            r_rnd     <= '0;
            for (int j = 0; j < 8; j++) begin
                r_h[j] <= INIT_HASH[255 - 32*j -: 32];
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: if (i_cmd_valid) begin
                    r_byte    <= i_cmd.data_byte;
                    r_closing <= i_cmd.end_of_message;
                    r_ret     <= RET_IDLE;
                    if (i_cmd.has_byte) begin
                        r_len <= r_len + 64'd8;
                    end
                end
                ST_LOAD: begin
                    // Shift the byte into its word, then step the fill.
                    r_w[r_fill[5:2]] <= {r_w[r_fill[5:2]][23:0], r_byte};
                    r_fill <= r_fill + 6'd1;
                    if (r_ret == RET_LEN) begin
                        r_len_snap <= {r_len_snap[55:0], 8'h00};
                    end
                    if (r_fill == 6'd63) begin
                        r_rnd <= '0;
                        for (int j = 0; j < 8; j++) begin
                            r_v[j] <= r_h[j];
                        end
                    end
                end
                ST_RND: begin
                    r_rnd <= r_rnd + 6'd1;
                    r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    // Window rotates; word for this round enters at the tail.
                    for (int j = 0; j < 15; j++) begin
                        r_w[j] <= r_w[j+1];
                    end
                    r_w[15] <= w_wcur;
                end
                ST_ADD: begin
                    for (int j = 0; j < 8; j++) begin
                        r_h[j] <= r_h[j] + r_v[j];
                    end
                end
                ST_PAD: begin
                    // The first padding byte is 0x80 and captures the length.
                    if (r_ret == RET_IDLE) begin
                        r_byte     <= PAD_BYTE;
                        r_len_snap <= r_len;
                    end else begin
                        r_byte <= 8'h00;
                    end
                    r_ret <= RET_PAD;
                end
                ST_LEN: begin
                    r_byte <= w_lbyte;
                    r_ret  <= RET_LEN;
                end
                ST_OUT: if (i_pop) begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd7) begin
                        r_fill    <= '0;
                        r_len     <= '0;
                        r_closing <= 1'b0;
                        r_ret     <= RET_IDLE;
                        for (int j = 0; j < 8; j++) begin
                            r_h[j] <= INIT_HASH[255 - 32*j -: 32];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_fill == 6'd0)) else $error("digest before block end");
    a_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd_pop) else $error("command taken while busy");
    a_len_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_fill >= LEN_FILL)) else $error("length byte misplaced");

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the SHA-256 stream hasher: random byte streams checked against a digest predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top
    import sha_pkg::*;
();

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_has_byte = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_message = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_beat;

    t_cmd         pending_beats[$];
    t_digest_beat expected_words[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           stimulus_done = 1'b0;
    int           hold_off_cycles = 0;
    bit           long_hold_done = 1'b0;

    // Predictor state.
    logic [31:0] hash_acc[8];
    logic [31:0] msg_block[16];
    logic [5:0]  fill_count;
    logic [63:0] msg_bits;

    sha256_stream_hasher i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_has_byte(i_has_byte), .i_data_byte(i_data_byte),
        .i_end_of_message(i_end_of_message), .empty(empty), .pop(pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] ror32(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] k_const(int r);
        logic [31:0] k_tab[64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return k_tab[r];
    endfunction

    function automatic void load_initial_hash();
        for (int j = 0; j < 8; j++) begin
            hash_acc[j] = INIT_HASH[255 - 32 * j -: 32];
        end
    endfunction

    // One 64-round compression of the current message block.
    function automatic void compress_block();
        logic [31:0] v[8];
        logic [31:0] sched[64];
        logic [31:0] t1, t2;
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                sched[r] = msg_block[r];
            end else begin
                sched[r] = (ror32(sched[r-2], 17) ^ ror32(sched[r-2], 19) ^ (sched[r-2] >> 10))
                         + sched[r-7]
                         + (ror32(sched[r-15], 7) ^ ror32(sched[r-15], 18) ^ (sched[r-15] >> 3))
                         + sched[r-16];
            end
        end
        v = hash_acc;
        for (int r = 0; r < 64; r++) begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(r) + sched[r];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++) begin
            hash_acc[j] += v[j];
        end
    endfunction

    function automatic void append_byte(logic [7:0] b);
        msg_block[fill_count[5:2]] = {msg_block[fill_count[5:2]][23:0], b};
        fill_count++;
        if (fill_count == 6'd0) begin
            compress_block();
        end
    endfunction

    // Add one beat to the tail of the stimulus queue.
    function automatic void append_beat(t_cmd c);
        pending_beats = {pending_beats, c};
    endfunction

    // Advance the hash for one accepted beat and queue the digest on end of message.
    function automatic void hash_beat(t_cmd c);
        logic [63:0] len;
        t_digest_beat d;
        if (c.has_byte) begin
            append_byte(c.data_byte);
            msg_bits += 64'd8;
        end
        if (c.end_of_message) begin
            len = msg_bits;
            append_byte(PAD_BYTE);
            while (fill_count != LEN_FILL) begin
                append_byte(8'h00);
            end
            for (int i = 7; i >= 0; i--) begin
                append_byte(len[8 * i +: 8]);
            end
            for (int i = 0; i < 8; i++) begin
                d.word = hash_acc[i];
                d.index = 3'(i);
                d.last = (i == 7);
                expected_words = {expected_words, d};
            end
            load_initial_hash();
            fill_count = '0;
            msg_bits = '0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic void add_message(int nbytes, bit empty_end, int idle_pct);
        t_cmd c;
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(99) < idle_pct) begin
                c.has_byte = 1'b0;
                c.data_byte = 8'($urandom);
                c.end_of_message = 1'b0;
                append_beat(c);
            end
            c.has_byte = 1'b1;
            c.data_byte = 8'($urandom);
            c.end_of_message = (!empty_end && i == nbytes - 1);
            append_beat(c);
        end
        if (empty_end || nbytes == 0) begin
            c.has_byte = 1'b0;
            c.data_byte = 8'($urandom);
            c.end_of_message = 1'b1;
            append_beat(c);
        end
    endfunction

    // Stimulus: directed messages around the padding boundaries, then random ones.
    initial begin
        t_cmd c;
        load_initial_hash();
        fill_count = '0;
        msg_bits = '0;
        for (int j = 0; j < 16; j++) begin
            msg_block[j] = '0;
        end
        // Empty message, then one byte with end, then extreme byte values.
        add_message(0, 1'b1, 0);
        c.has_byte = 1'b1; c.data_byte = 8'hff; c.end_of_message = 1'b1;
        append_beat(c);
        c.data_byte = 8'h00; c.end_of_message = 1'b0;
        append_beat(c);
        c.has_byte = 1'b0; c.data_byte = 8'hff;
        append_beat(c);
        c.end_of_message = 1'b1;
        append_beat(c);
        // Lengths that straddle the length field and the block boundary.
        add_message(55, 1'b0, 0);
        add_message(56, 1'b1, 0);
        add_message(64, 1'b0, 0);
        add_message(119, 1'b0, 5);
        while (pending_beats.size() < 330) begin
            case ($urandom_range(3))
                0: add_message($urandom_range(0, 8), 1'($urandom_range(1)), 20);
                1: add_message($urandom_range(50, 70), 1'($urandom_range(1)), 5);
                default: add_message($urandom_range(0, 40), 1'($urandom_range(1)), 10);
            endcase
        end
        for (int i = 0; i < 4; i++) begin
            c.has_byte = 1'b0; c.data_byte = 8'($urandom); c.end_of_message = 1'b0;
            append_beat(c);
        end
        c.end_of_message = 1'b1;
        append_beat(c);
    end

    // Reset and run-end control.
    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && expected_words.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[sha256_stream_hasher] OK");
        end else begin
            $display("[sha256_stream_hasher] ERROR");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cycle limit reached");
            $display("[sha256_stream_hasher] ERROR");
            $finish;
        end
    end

    // Driver: offers one beat at a time with random gaps.
    int send_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) begin
                hash_beat(pending_beats.pop_front());
                send_gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 16);
                if (cycle_count < 3000) send_gap = 0;
            end
            if (push && full) begin
                // Keep offering the same beat.
            end else if (send_gap > 0) begin
                push <= 1'b0;
                send_gap--;
            end else if (pending_beats.size() > 0) begin
                push <= 1'b1;
                i_has_byte <= pending_beats[0].has_byte;
                i_data_byte <= pending_beats[0].data_byte;
                i_end_of_message <= pending_beats[0].end_of_message;
            end else begin
                push <= 1'b0;
                stimulus_done <= 1'b1;
            end
        end
    end

    // Long receiver hold-off: once, early in the run, stop taking words for many cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!long_hold_done && cycle_count > 200) begin
                long_hold_done <= 1'b1;
                hold_off_cycles <= 3000;
            end else if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
            end
        end
    end

    // Monitor: pops digest words with random stalls.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", o_digest_word, 32'h0);
                end else begin
                    if (o_digest_word !== expected_words[0].word)
                        report_mismatch("digest_word", o_digest_word, expected_words[0].word);
                    if (o_word_index !== expected_words[0].index)
                        report_mismatch("word_index", 32'(o_word_index),
                                        32'(expected_words[0].index));
                    if (o_last_word !== expected_words[0].last)
                        report_mismatch("last_word", 32'(o_last_word),
                                        32'(expected_words[0].last));
                    void'(expected_words.pop_front());
                end
                recv_gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 16);
            end
            if (hold_off_cycles > 0) begin
                pop <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire
